[hw/rtl/pitc_pkg.sv]
// Package with the types, constants and arithmetic steps of the plane index to coordinates unit.
`default_nettype none

package pitc_pkg;

  localparam int unsigned IndexWidth  = 32;
  localparam int unsigned SizeWidth   = 16;
  localparam int unsigned OffWidth    = 16;
  localparam int unsigned CoordWidth  = 16;
  localparam int unsigned ChanWidth   = 17;
  localparam int unsigned NumPos      = 4;
  localparam int unsigned AxisWidth   = 2;
  localparam int unsigned DimsWidth   = 3;
  localparam int unsigned OrderWidth  = 8;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned RemWidth    = SizeWidth + 1;

  localparam int unsigned DivBits  = 8;
  localparam int unsigned DivSteps = IndexWidth / DivBits;
  localparam int unsigned ModBits  = 6;
  localparam int unsigned ModSteps = 3;
  localparam int unsigned ModWidth = ModBits * ModSteps;

  localparam int unsigned MidDepthDefault = 4;
  localparam int unsigned OutDepthDefault = 32;

  localparam logic [DimsWidth-1:0] FourDims = 3'd4;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgNumDims     = 3'd0,
    CfgDimOrder    = 3'd1,
    CfgDepthSize   = 3'd2,
    CfgChannelSize = 3'd3,
    CfgTimeSize    = 3'd4,
    CfgSceneSize   = 3'd5,
    CfgFirstPlane  = 3'd6
  } cfg_idx_e;

  typedef enum logic [AxisWidth-1:0] {
    AxisDepth   = 2'd0,
    AxisChannel = 2'd1,
    AxisTime    = 2'd2,
    AxisScene   = 2'd3
  } axis_e;

  typedef struct packed {
    logic [IndexWidth-1:0]                diff;
    logic [NumPos-1:0][SizeWidth-1:0]     size;
    logic [NumPos-1:0][OffWidth-1:0]      off;
    logic [NumPos-1:0][AxisWidth-1:0]     axis;
    logic                                 four;
    logic                                 bad;
  } item_t;

  typedef struct packed {
    logic [IndexWidth-1:0] num;
    logic [RemWidth-1:0]   rem;
    logic [IndexWidth-1:0] quo;
  } div_t;

  typedef struct packed {
    item_t                            item;
    div_t                             dv;
    logic [NumPos-1:0][SizeWidth-1:0] loc;
  } work_t;

  typedef struct packed {
    logic [ModWidth-1:0] num;
    logic [RemWidth-1:0] rem;
  } modl_t;

  typedef struct packed {
    item_t             item;
    modl_t [NumPos-1:0] lane;
  } mod_t;

  typedef struct packed {
    logic                  valid_res;
    logic [CoordWidth-1:0] depth_coord;
    logic [ChanWidth-1:0]  channel_coord;
    logic [CoordWidth-1:0] time_coord;
    logic [CoordWidth-1:0] scene_coord;
  } res_t;

  function automatic div_t div_step(div_t a, logic [SizeWidth-1:0] s);
    div_t                r;
    logic [RemWidth-1:0] t;
    r = a;
    for (int j = 0; j < DivBits; j++) begin
      t     = {r.rem[SizeWidth-1:0], r.num[IndexWidth-1]};
      r.num = {r.num[IndexWidth-2:0], 1'b0};
      if (t >= {1'b0, s}) begin
        r.rem = t - {1'b0, s};
        r.quo = {r.quo[IndexWidth-2:0], 1'b1};
      end else begin
        r.rem = t;
        r.quo = {r.quo[IndexWidth-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic modl_t mod_step(modl_t a, logic [SizeWidth-1:0] s);
    modl_t               r;
    logic [RemWidth-1:0] t;
    r = a;
    for (int j = 0; j < ModBits; j++) begin
      t     = {r.rem[SizeWidth-1:0], r.num[ModWidth-1]};
      r.num = {r.num[ModWidth-2:0], 1'b0};
      if (t >= {1'b0, s}) begin
        r.rem = t - {1'b0, s};
      end else begin
        r.rem = t;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/pitc_fifo.sv]
// Small register queue used between the front and back parts and at the result side.
`default_nettype none

module pitc_fifo #(
  parameter int unsigned Depth = 4,
  parameter type         T     = logic
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wvalid_i,
  input  wire T     wdata_i,
  output logic      full_o,
  input  wire logic rready_i,
  output T          rdata_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  T                mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            wr_en, rd_en;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = wvalid_i & ~full_o;
  assign rd_en   = rready_i & ~empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (wr_en) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (rd_en) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(wr_en) - CntW'(rd_en);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pitc_front.sv]
// Front part: configuration registers, range check and per-position operand selection.
`default_nettype none

module pitc_front
  import pitc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  input  wire logic [CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [IndexWidth-1:0]  cfg_data_i,
  input  wire logic [IndexWidth-1:0]  plane_index_i,
  input  wire logic [OffWidth-1:0]    offset_depth_i,
  input  wire logic [OffWidth-1:0]    offset_channel_i,
  input  wire logic [OffWidth-1:0]    offset_time_i,
  input  wire logic [OffWidth-1:0]    offset_scene_i,
  output item_t                       item_o
);

  logic [DimsWidth-1:0]             num_dims_q;
  logic [OrderWidth-1:0]            dim_order_q;
  logic [NumPos-1:0][SizeWidth-1:0] size_q;
  logic [IndexWidth-1:0]            first_q;
  logic [NumPos-1:0][OffWidth-1:0]  off_in;

  assign off_in = {offset_scene_i, offset_time_i, offset_channel_i, offset_depth_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q  <= 3'd3;
      dim_order_q <= 8'd56;
      size_q      <= {NumPos{SizeWidth'(1)}};
      first_q     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgNumDims:     num_dims_q          <= cfg_data_i[DimsWidth-1:0];
        CfgDimOrder:    dim_order_q         <= cfg_data_i[OrderWidth-1:0];
        CfgDepthSize:   size_q[AxisDepth]   <= cfg_data_i[SizeWidth-1:0];
        CfgChannelSize: size_q[AxisChannel] <= cfg_data_i[SizeWidth-1:0];
        CfgTimeSize:    size_q[AxisTime]    <= cfg_data_i[SizeWidth-1:0];
        CfgSceneSize:   size_q[AxisScene]   <= cfg_data_i[SizeWidth-1:0];
        CfgFirstPlane:  first_q             <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic                 zero;
    logic                 below;
    logic [AxisWidth-1:0] ax;
    item_o      = '0;
    zero        = 1'b0;
    item_o.four = (num_dims_q == FourDims);
    for (int i = 0; i < NumPos; i++) begin
      ax             = dim_order_q[2*i +: AxisWidth];
      item_o.axis[i] = ax;
      if (i < NumPos - 1 || item_o.four) begin
        item_o.size[i] = size_q[ax];
        item_o.off[i]  = off_in[ax];
        zero           = zero | (size_q[ax] == '0);
      end else begin
        item_o.size[i] = SizeWidth'(1);
        item_o.off[i]  = '0;
      end
    end
    below       = (plane_index_i < first_q);
    item_o.diff = below ? '0 : plane_index_i - first_q;
    item_o.bad  = below | zero;
  end

endmodule

`default_nettype wire

[hw/rtl/pitc_back.sv]
// Back part: pipelined digit extraction, offset carry, wrap remainder and coordinate mapping.
`default_nettype none

module pitc_back
  import pitc_pkg::*;
#(
  parameter int unsigned OutDepth = OutDepthDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  item_valid_i,
  input  wire item_t item_i,
  output logic       item_pop_o,
  input  wire logic  res_taken_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  localparam int unsigned NDiv = DivSteps * NumPos;
  localparam int unsigned CntW = $clog2(OutDepth + 1);

  logic [CntW-1:0] cnt_q, cnt_d;

  assign item_pop_o = item_valid_i & (cnt_q < CntW'(OutDepth));

  always_comb begin
    cnt_d = cnt_q + CntW'(item_pop_o) - CntW'(res_taken_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  work_t entry;
  work_t div_q [NDiv];
  logic  div_v_q [NDiv];

  always_comb begin
    entry        = '0;
    entry.item   = item_i;
    entry.dv.num = item_i.diff;
  end

  for (genvar k = 0; k < NDiv; k++) begin : g_div
    work_t src, nxt;
    logic  src_v;
    if (k == 0) begin : g_first
      assign src   = entry;
      assign src_v = item_pop_o;
    end else begin : g_rest
      assign src   = div_q[k-1];
      assign src_v = div_v_q[k-1];
    end
    always_comb begin
      nxt    = src;
      nxt.dv = div_step(src.dv, src.item.size[k / DivSteps]);
      if ((k % DivSteps) == DivSteps - 1) begin
        nxt.loc[k / DivSteps] = nxt.dv.rem[SizeWidth-1:0];
        nxt.dv.num            = nxt.dv.quo;
        nxt.dv.rem            = '0;
        nxt.dv.quo            = '0;
      end
    end
    always_ff @(posedge clk_i) begin
      div_q[k] <= nxt;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_v_q[k] <= 1'b0;
      end else begin
        div_v_q[k] <= src_v;
      end
    end
  end

  mod_t carry_d;
  mod_t mod_q [ModSteps+1];
  logic mod_v_q [ModSteps+1];

  always_comb begin
    work_t               w;
    logic                c;
    logic                ge;
    logic [RemWidth-1:0] sum;
    w             = div_q[NDiv-1];
    carry_d       = '0;
    carry_d.item  = w.item;
    carry_d.item.bad = w.item.bad | (w.dv.num != '0);
    c             = 1'b0;
    for (int i = 0; i < NumPos; i++) begin
      sum = {1'b0, w.loc[i]} + {1'b0, w.item.off[i]} + RemWidth'(c);
      ge  = (sum >= {1'b0, w.item.size[i]});
      carry_d.lane[i].num = ModWidth'(sum);
      if (i == NumPos - 1 || (i == NumPos - 2 && !w.item.four)) begin
        if (i == NumPos - 1 && !w.item.four) begin
          c = 1'b0;
        end else begin
          carry_d.item.bad = carry_d.item.bad | ge;
          c = 1'b0;
        end
      end else begin
        c = ge;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mod_q[0] <= carry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_v_q[0] <= 1'b0;
    end else begin
      mod_v_q[0] <= div_v_q[NDiv-1];
    end
  end

  for (genvar m = 0; m < ModSteps; m++) begin : g_mod
    mod_t nxt;
    always_comb begin
      nxt = mod_q[m];
      for (int i = 0; i < NumPos; i++) begin
        nxt.lane[i] = mod_step(mod_q[m].lane[i], mod_q[m].item.size[i]);
      end
    end
    always_ff @(posedge clk_i) begin
      mod_q[m+1] <= nxt;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mod_v_q[m+1] <= 1'b0;
      end else begin
        mod_v_q[m+1] <= mod_v_q[m];
      end
    end
  end

  res_t res_d, res_q;
  logic res_v_q;

  always_comb begin
    mod_t                              f;
    logic [NumPos-1:0][CoordWidth-1:0] coord;
    f     = mod_q[ModSteps];
    coord = '0;
    for (int i = 0; i < NumPos; i++) begin
      if (i < NumPos - 1 || f.item.four) begin
        coord[f.item.axis[i]] = f.lane[i].rem[CoordWidth-1:0];
      end
    end
    res_d = '0;
    if (!f.item.bad) begin
      res_d.valid_res     = 1'b1;
      res_d.depth_coord   = coord[AxisDepth];
      res_d.channel_coord = f.item.four ? {1'b0, coord[AxisChannel]} : '1;
      res_d.time_coord    = coord[AxisTime];
      res_d.scene_coord   = coord[AxisScene];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else begin
      res_v_q <= mod_v_q[ModSteps];
    end
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

[hw/rtl/plane_index_to_coordinates_unit.sv]
// Top level of the plane index to coordinates unit.
// The unit accepts one plane index per cycle while full is low and returns one result per
// index, in order. The back pipeline has 16 stages that divide out one position size per
// 4 stages at 8 quotient bits each, one carry stage, 3 remainder stages and one mapping
// stage. At most 32 items are in flight between the intermediate queue and the result
// queue, so full throughput holds while results are popped every cycle. Configuration
// writes are always ready.
`default_nettype none

module plane_index_to_coordinates_unit
  import pitc_pkg::*;
#(
  parameter int unsigned MidDepth = MidDepthDefault,
  parameter int unsigned OutDepth = OutDepthDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [IndexWidth-1:0]  cfg_data_i,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [IndexWidth-1:0]  plane_index_i,
  input  wire logic [OffWidth-1:0]    offset_depth_i,
  input  wire logic [OffWidth-1:0]    offset_channel_i,
  input  wire logic [OffWidth-1:0]    offset_time_i,
  input  wire logic [OffWidth-1:0]    offset_scene_i,
  output logic                        empty,
  input  wire logic                   pop,
  output logic                        valid_res_o,
  output logic [CoordWidth-1:0]       depth_coord_o,
  output logic signed [ChanWidth-1:0] channel_coord_o,
  output logic [CoordWidth-1:0]       time_coord_o,
  output logic [CoordWidth-1:0]       scene_coord_o
);

  item_t front_item, mid_item;
  logic  mid_empty, mid_pop;
  logic  res_valid, res_taken;
  res_t  res, out_res;

  assign cfg_ready_o = 1'b1;

  pitc_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .plane_index_i,
    .offset_depth_i,
    .offset_channel_i,
    .offset_time_i,
    .offset_scene_i,
    .item_o           (front_item)
  );

  pitc_fifo #(
    .Depth (MidDepth),
    .T     (item_t)
  ) u_mid_fifo (
    .clk_i,
    .rst_ni,
    .wvalid_i (push),
    .wdata_i  (front_item),
    .full_o   (full),
    .rready_i (mid_pop),
    .rdata_o  (mid_item),
    .empty_o  (mid_empty)
  );

  pitc_back #(
    .OutDepth (OutDepth)
  ) u_back (
    .clk_i,
    .rst_ni,
    .item_valid_i (~mid_empty),
    .item_i       (mid_item),
    .item_pop_o   (mid_pop),
    .res_taken_i  (res_taken),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  logic out_full;

  pitc_fifo #(
    .Depth (OutDepth),
    .T     (res_t)
  ) u_out_fifo (
    .clk_i,
    .rst_ni,
    .wvalid_i (res_valid),
    .wdata_i  (res),
    .full_o   (out_full),
    .rready_i (pop),
    .rdata_o  (out_res),
    .empty_o  (empty)
  );

  assign res_taken       = pop & ~empty & ~(out_full & 1'b0);
  assign valid_res_o     = out_res.valid_res;
  assign depth_coord_o   = out_res.depth_coord;
  assign channel_coord_o = $signed(out_res.channel_coord);
  assign time_coord_o    = out_res.time_coord;
  assign scene_coord_o   = out_res.scene_coord;

endmodule

`default_nettype wire
